### src/mme_pkg.sv
// shared types and constants of the matrix multiply engine
package mme_pkg;

   localparam int DIM_W    = 5;
   localparam int IDX_W    = 4;
   localparam int ELEM_W   = 16;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int DOT_W    = 36;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd2;

   typedef struct packed {
      logic [1:0]              func;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [ELEM_W-1:0] elem_value;
   } mme_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [DOT_W-1:0] dot_value;
      logic                    row_last;
   } mme_rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD_A,
      CMD_LOAD_B,
      CMD_COMPUTE
   } mme_cmd_kind_type;

   typedef struct packed {
      mme_cmd_kind_type        kind;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic [ELEM_W-1:0]       value;
   } mme_cmd_type;

   // effective matrix sizes after clamping
   typedef struct packed {
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] k;
      logic [DIM_W-1:0] n;
   } mme_dims_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mme_qstat_type;

endpackage

### src/mme_ram.sv
// generic simple dual port ram with registered read
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mme_queue.sv
// short command queue between front and back
module mme_queue
   import mme_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mme_cmd_type   push_cmd,
   input  logic          pop,
   output mme_cmd_type   head_cmd,
   output mme_qstat_type stat
);

   mme_cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/mme_front.sv
// front end: accepts request words, drops ignored ones, queues commands
module mme_front
   import mme_pkg::*;
(
   input  logic          req_valid,
   output logic          req_ready,
   input  mme_req_type   req_data,
   input  mme_dims_type  dims,
   input  mme_qstat_type q_stat,
   output logic          push,
   output mme_cmd_type   push_cmd
);

   logic row_in_m, row_in_k, col_in_k, col_in_n;
   logic keep;

   assign row_in_m = {1'b0, req_data.row_index} < dims.m;
   assign row_in_k = {1'b0, req_data.row_index} < dims.k;
   assign col_in_k = {1'b0, req_data.col_index} < dims.k;
   assign col_in_n = {1'b0, req_data.col_index} < dims.n;

   always_comb begin
      keep          = 1'b0;
      push_cmd.kind = CMD_COMPUTE;
      case (req_data.func)
         FUNC_LOAD_A: begin
            keep          = row_in_m && col_in_k;
            push_cmd.kind = CMD_LOAD_A;
         end
         FUNC_LOAD_B: begin
            keep          = row_in_k && col_in_n;
            push_cmd.kind = CMD_LOAD_B;
         end
         FUNC_COMPUTE: begin
            // an empty result row gives nothing at all
            keep          = row_in_m && (dims.n != '0);
            push_cmd.kind = CMD_COMPUTE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push_cmd.row   = req_data.row_index;
      push_cmd.col   = req_data.col_index;
      push_cmd.value = req_data.elem_value;
   end

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready && keep;

endmodule

### src/mme_back.sv
// back end: element stores, multiply-accumulate sequencer, result register
module mme_back
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  mme_cmd_type   head_cmd,
   input  mme_qstat_type q_stat,
   output logic          pop,
   input  mme_dims_type  dims,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output mme_rsp_type   rsp_data
);

   localparam int StoreDepth = MAX_DIM * MAX_DIM;
   localparam int AddrW      = $clog2(StoreDepth);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DELIVER
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         row_ff, row_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]         l_ff, l_in;
   logic signed [DOT_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     p1_valid_ff, p1_valid_in;
   logic                     p2_valid_ff, p2_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mme_rsp_type              rsp_data_ff, rsp_data_in;

   logic                     a_wr_en, b_wr_en, rd_en;
   logic [AddrW-1:0]         wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0]        a_rd_data, b_rd_data;
   logic                     k_last, j_last, slot_free;

   function automatic logic [AddrW-1:0] store_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      store_addr = AddrW'(32'(r) * MAX_DIM + 32'(c));
   endfunction

   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign a_wr_en   = pop && (head_cmd.kind == CMD_LOAD_A);
   assign b_wr_en   = pop && (head_cmd.kind == CMD_LOAD_B);
   assign wr_addr   = store_addr(head_cmd.row, head_cmd.col);
   assign rd_en     = (state_ff == ST_ISSUE);
   assign a_rd_addr = store_addr(row_ff, l_ff);
   assign b_rd_addr = store_addr(l_ff, j_ff);

   mme_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(StoreDepth)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (head_cmd.value),
      .rd_en   (rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mme_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(StoreDepth)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (head_cmd.value),
      .rd_en   (rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign k_last    = ({1'b0, l_ff} == dims.k - 1'b1);
   assign j_last    = ({1'b0, j_ff} == dims.n - 1'b1);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      j_in         = j_ff;
      l_in         = l_ff;
      p1_valid_in  = rd_en;
      p2_valid_in  = p1_valid_ff;
      prod_in      = $signed(a_rd_data) * $signed(b_rd_data);
      acc_in       = p2_valid_ff ? acc_ff + DOT_W'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && (head_cmd.kind == CMD_COMPUTE)) begin
               row_in   = head_cmd.row;
               j_in     = '0;
               l_in     = '0;
               acc_in   = '0;
               state_in = (dims.k == '0) ? ST_DELIVER : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            l_in = l_ff + 1'b1;
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to land in the accumulator
            if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_row   = row_ff;
               rsp_data_in.out_col   = j_ff;
               rsp_data_in.dot_value = acc_ff;
               rsp_data_in.row_last  = j_last;
               if (j_last) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  l_in     = '0;
                  acc_in   = '0;
                  state_in = (dims.k == '0) ? ST_DELIVER : ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      j_ff        <= j_in;
      l_ff        <= l_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/matrix_multiply_engine.sv
// top level of the matrix multiply engine: size registers, front, queue, back
//
//   channel   direction  handshake              word
//   req       in         req_valid/req_ready    mme_req_type
//   rsp       out        rsp_valid/rsp_ready    mme_rsp_type
//   csr       in         csr_write_en           csr_index, csr_wdata
//
// a load is written into its store as it leaves the queue.
// a row request is computed one result column after another by the single
// multiply-accumulate unit fed by one read port on each store; a zero inner
// size skips the reads.
// reset is synchronous; sizes return to 16, store contents are left as they are.
// the four-word queue lets requests arrive while a row is computed; a stalled
// result register holds the back end, a full queue holds req_ready low.
module matrix_multiply_engine
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mme_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mme_rsp_type          rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int DimCap = (MAX_DIM < 16) ? MAX_DIM : 16;

   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] inner_ff, inner_in;
   logic [DIM_W-1:0] cols_b_ff, cols_b_in;
   mme_dims_type     dims;
   mme_qstat_type    q_stat;
   mme_cmd_type      push_cmd, head_cmd;
   logic             push, pop;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      clamp_dim = (v > DIM_W'(DimCap)) ? DIM_W'(DimCap) : v;
   endfunction

   always_comb begin
      rows_a_in = rows_a_ff;
      inner_in  = inner_ff;
      cols_b_in = cols_b_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ROWS_A: rows_a_in = csr_wdata;
            CSR_INNER:  inner_in  = csr_wdata;
            CSR_COLS_B: cols_b_in = csr_wdata;
            default:    rows_a_in = rows_a_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_W'(16);
         inner_ff  <= DIM_W'(16);
         cols_b_ff <= DIM_W'(16);
      end else begin
         rows_a_ff <= rows_a_in;
         inner_ff  <= inner_in;
         cols_b_ff <= cols_b_in;
      end
   end

   assign dims.m = clamp_dim(rows_a_ff);
   assign dims.k = clamp_dim(inner_ff);
   assign dims.n = clamp_dim(cols_b_ff);

   mme_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .dims      (dims),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   mme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   mme_back #(
      .MAX_DIM(MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_stat    (q_stat),
      .pop       (pop),
      .dims      (dims),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // the last word of a row sits in the final column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_last |-> ({1'b0, rsp_data.out_col} == dims.n - 1'b1))
      else $error("row_last not on final column");

   // any other word sits before the final column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.row_last |-> ({1'b0, rsp_data.out_col} < dims.n - 1'b1))
      else $error("result column past end of row");

   // queue fill level stays consistent
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

endmodule
